[sv/rsd_pkg.sv]
// shared types and constants for the record stream deframer
package rsd_pkg;

  // default width of the stream byte offset counter
  localparam int OFFSET_BITS_DEF = 48;
  // width of the reported record offset
  localparam int REC_OFF_W = 48;

  // header layout: type byte, 4 timecode bytes, 4 length bytes
  localparam logic [3:0] HDR_LAST   = 4'd8;
  localparam logic [3:0] IN_PAYLOAD = 4'd9;
  localparam logic [3:0] TC_BYTE0   = 4'd1;
  localparam logic [3:0] TC_BYTE1   = 4'd2;
  localparam logic [3:0] TC_BYTE2   = 4'd3;
  localparam logic [3:0] TC_BYTE3   = 4'd4;
  localparam logic [3:0] LEN_BYTE0  = 4'd5;
  localparam logic [3:0] LEN_BYTE1  = 4'd6;
  localparam logic [3:0] LEN_BYTE2  = 4'd7;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_KEYFRAME_TYPE = 1'b0;
  localparam logic REG_MAX_PAYLOAD   = 1'b1;
  localparam int   CFG_ADDR_W        = 3;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

  // packed output widths
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [2:0] {
    ST_HDR   = 3'd0,
    ST_DONE  = 3'd1,
    ST_PAY   = 3'd2,
    ST_OVER  = 3'd3,
    ST_END   = 3'd4,
    ST_TRUNC = 3'd5,
    ST_HALT  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  keyframe_type;
    logic [31:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           record_type;
    logic [31:0]          timecode;
    logic [31:0]          payload_length;
    logic [REC_OFF_W-1:0] record_offset;
    logic [7:0]           payload_byte;
    logic                 last_of_record;
    logic                 is_keyframe;
    logic [31:0]          keyframe_count;
    logic [31:0]          duration;
  } result_t;

endpackage

[sv/rsd_cfg.sv]
// configuration registers behind the apb-style port
module rsd_cfg
  import rsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [7:0]  keyframe_type_r;
  logic [31:0] max_payload_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyframe_type_r <= 8'd0;
      max_payload_r   <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        REG_KEYFRAME_TYPE: keyframe_type_r <= cfg_pwdata[7:0];
        REG_MAX_PAYLOAD:   max_payload_r   <= cfg_pwdata;
        default:           ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_paddr[2])
      REG_KEYFRAME_TYPE: cfg_prdata = {24'd0, keyframe_type_r};
      REG_MAX_PAYLOAD:   cfg_prdata = max_payload_r;
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.keyframe_type = keyframe_type_r;
  assign cfg.max_payload   = max_payload_r;

endmodule

[sv/rsd_in_reg.sv]
// input register stage holding one stream item
module rsd_in_reg
  import rsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  // stage accepts when empty or when its item moves on this cycle
  assign in_tready  = ~valid_r | take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

[sv/rsd_parser.sv]
// record header assembly, payload countdown and counters
module rsd_parser
  import rsd_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [3:0]             header_position_r, header_position_nxt;
  logic [7:0]             current_type_r, current_type_nxt;
  logic [31:0]            current_timecode_r, current_timecode_nxt;
  logic [31:0]            current_length_r, current_length_nxt;
  logic [31:0]            bytes_remaining_r, bytes_remaining_nxt;
  logic [OFFSET_BITS-1:0] stream_position_r, stream_position_nxt;
  logic [OFFSET_BITS-1:0] record_start_r, record_start_nxt;
  logic [31:0]            keyframes_seen_r, keyframes_seen_nxt;
  logic [31:0]            last_timecode_r, last_timecode_nxt;
  logic                   halted_r, halted_nxt;
  status_t                status;
  logic [7:0]             payload_byte;
  logic                   last_flag;
  logic [31:0]            remaining_dec;

  // one step of the deframer for the item in the input register
  always_comb begin
    header_position_nxt  = header_position_r;
    current_type_nxt     = current_type_r;
    current_timecode_nxt = current_timecode_r;
    current_length_nxt   = current_length_r;
    bytes_remaining_nxt  = bytes_remaining_r;
    stream_position_nxt  = stream_position_r;
    record_start_nxt     = record_start_r;
    keyframes_seen_nxt   = keyframes_seen_r;
    last_timecode_nxt    = last_timecode_r;
    halted_nxt           = halted_r;
    status               = ST_HALT;
    payload_byte         = 8'd0;
    last_flag            = 1'b0;
    remaining_dec        = (bytes_remaining_r != 32'd0) ? bytes_remaining_r - 32'd1 : 32'd0;

    if (halted_r) begin
      status = ST_HALT;
    end else if (item.end_of_stream) begin
      // end marker: clean only at a record boundary
      status              = (header_position_r == 4'd0) ? ST_END : ST_TRUNC;
      header_position_nxt = 4'd0;
      bytes_remaining_nxt = 32'd0;
    end else begin
      stream_position_nxt = stream_position_r + OFFSET_BITS'(1);
      if (header_position_r >= IN_PAYLOAD) begin
        // payload pass-through with countdown
        bytes_remaining_nxt = remaining_dec;
        last_flag           = (remaining_dec == 32'd0);
        if (last_flag) begin
          header_position_nxt = 4'd0;
        end
        status       = ST_PAY;
        payload_byte = item.data_byte;
      end else begin
        // header byte lanes
        case (header_position_r)
          4'd0: begin
            record_start_nxt     = stream_position_r;
            current_type_nxt     = item.data_byte;
            current_timecode_nxt = 32'd0;
            current_length_nxt   = 32'd0;
          end
          TC_BYTE0:  current_timecode_nxt[7:0]   = item.data_byte;
          TC_BYTE1:  current_timecode_nxt[15:8]  = item.data_byte;
          TC_BYTE2:  current_timecode_nxt[23:16] = item.data_byte;
          TC_BYTE3:  current_timecode_nxt[31:24] = item.data_byte;
          LEN_BYTE0: current_length_nxt[7:0]     = item.data_byte;
          LEN_BYTE1: current_length_nxt[15:8]    = item.data_byte;
          LEN_BYTE2: current_length_nxt[23:16]   = item.data_byte;
          default:   current_length_nxt[31:24]   = item.data_byte;
        endcase

        if (header_position_r != HDR_LAST) begin
          header_position_nxt = header_position_r + 4'd1;
          status              = ST_HDR;
        end else if (current_length_nxt > cfg.max_payload) begin
          // oversize length stops the block until reset
          halted_nxt          = 1'b1;
          header_position_nxt = 4'd0;
          bytes_remaining_nxt = 32'd0;
          status              = ST_OVER;
        end else begin
          // header accepted
          if (current_type_nxt == cfg.keyframe_type && keyframes_seen_r != COUNT_MAX) begin
            keyframes_seen_nxt = keyframes_seen_r + 32'd1;
          end
          last_timecode_nxt = current_timecode_nxt;
          status            = ST_DONE;
          if (current_length_nxt == 32'd0) begin
            header_position_nxt = 4'd0;
            bytes_remaining_nxt = 32'd0;
            last_flag           = 1'b1;
          end else begin
            header_position_nxt = IN_PAYLOAD;
            bytes_remaining_nxt = current_length_nxt;
          end
        end
      end
    end
  end

  // result taken from the updated state
  always_comb begin
    res.status         = status;
    res.record_type    = current_type_nxt;
    res.timecode       = current_timecode_nxt;
    res.payload_length = current_length_nxt;
    res.record_offset  = REC_OFF_W'(record_start_nxt);
    res.payload_byte   = payload_byte;
    res.last_of_record = last_flag;
    res.is_keyframe    = (current_type_nxt == cfg.keyframe_type);
    res.keyframe_count = keyframes_seen_nxt;
    res.duration       = last_timecode_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_position_r  <= 4'd0;
      current_type_r     <= 8'd0;
      current_timecode_r <= 32'd0;
      current_length_r   <= 32'd0;
      bytes_remaining_r  <= 32'd0;
      stream_position_r  <= '0;
      record_start_r     <= '0;
      keyframes_seen_r   <= 32'd0;
      last_timecode_r    <= 32'd0;
      halted_r           <= 1'b0;
    end else if (step) begin
      header_position_r  <= header_position_nxt;
      current_type_r     <= current_type_nxt;
      current_timecode_r <= current_timecode_nxt;
      current_length_r   <= current_length_nxt;
      bytes_remaining_r  <= bytes_remaining_nxt;
      stream_position_r  <= stream_position_nxt;
      record_start_r     <= record_start_nxt;
      keyframes_seen_r   <= keyframes_seen_nxt;
      last_timecode_r    <= last_timecode_nxt;
      halted_r           <= halted_nxt;
    end
  end

`ifndef SYNTHESIS
  // oversize halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // header position never leaves its range
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_position_r <= IN_PAYLOAD)
    else $error("header position out of range");

  // payload phase always has bytes still to come
  a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (header_position_r == IN_PAYLOAD) |-> (bytes_remaining_r != 32'd0))
    else $error("payload phase with no bytes remaining");

  // a halted block changes no stream offset
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> $stable(stream_position_r))
    else $error("stream position moved while halted");
`endif

endmodule

[sv/rsd_out_reg.sv]
// result register on the master-side stream
module rsd_out_reg
  import rsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  result_t                res,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  logic    valid_r;
  result_t res_r;

  // register is free when empty or being drained this cycle
  assign free       = ~valid_r | out_tready;
  assign out_tvalid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  // pack result fields, lowest first
  assign out_tdata = {7'd0, res_r.duration, res_r.keyframe_count, res_r.is_keyframe,
                      res_r.payload_byte, res_r.record_offset, res_r.payload_length,
                      res_r.timecode, res_r.record_type};
  assign out_tuser = res_r.status;
  assign out_tlast = res_r.last_of_record;

endmodule

[sv/record_stream_deframer_core.sv]
// top level of the record stream deframer
//
// Takes a record stream one byte per item and returns exactly one result item per input
// item. Each record is a 9-byte header (type, little-endian 32-bit timecode, little-endian
// 32-bit length) followed by the payload bytes. The block sustains one item per clock
// while out_tready is high: an item waits in the input register, where the header assembly,
// payload countdown and keyframe/duration update are done in a single pass, and the result
// then sits in the output register until out_tready takes it.
// Both stages advance together, so a stalled output only holds the input back
// once both registers are full. An oversize length halts the block until reset; every
// later item then reports the halted status. Registers: keyframe_type at 0x0,
// max_payload at 0x4; write them only while no item is in flight.
module record_stream_deframer_core
  import rsd_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // slave side
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic [0:0]             in_tuser,   // [0] end_of_stream
  // master side
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] record_type, [39:8] timecode, [71:40] payload_length,
  // [119:72] record_offset, [127:120] payload_byte, [128] is_keyframe,
  // [160:129] keyframe_count, [192:161] duration, [199:193] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [2:0] status
  output logic                   out_tlast,  // last_of_record
  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    step;
  result_t res;

  assign in_item.data_byte     = in_tdata;
  assign in_item.end_of_stream = in_tuser[0];
  assign step                  = item_valid & out_free;

  rsd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  rsd_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  rsd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
